// ----- hdl/wfa_pkg.sv -----
// ----------------------------------------------------------------------------
// wfa_pkg: worst-fit allocator shared types and constants
// Table sizes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package wfa_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int ADDR_WIDTH = 16;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int LEN_W      = ADDR_WIDTH + 1;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_NOFIT   = 2'd1;
   localparam status_type ST_FULL    = 2'd2;
   localparam status_type ST_OVERLAP = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC,    // check largest block
      S_FSCAN,    // free: read entry p, find position
      S_FPREV,    // free: read entry p-1
      S_FDECIDE,  // free: overlap / merge decision
      S_SHDN,     // move entries down (remove)
      S_SHUP,     // move entries up (insert)
      S_LARGE,    // rescan for largest
      S_DONE
   } state_type;

endpackage

// ----- hdl/worst_fit_allocator_top.sv -----
// ----------------------------------------------------------------------------
// worst_fit_allocator_top: worst-fit free block allocator
// Free list sorted by base; allocate carves from the largest block.
// ----------------------------------------------------------------------------
// Usage: pulse start with req_func (0 allocate, 1 free), req_address and
// req_size while busy is low. busy rises the next cycle and stays high until
// the result is shown. rsp_valid marks rsp_address_out / rsp_status for one
// cycle; the receiver cannot stall it. An allocate that fails or asks for
// zero goes straight to the result; a split of the largest block rescans for
// the largest, and an exact fit first removes the entry by shifting the later
// entries down. A free scans for its place, reads the entry before it and
// decides; a merge then rescans for the largest, and an insert or a double
// merge first shifts the entries. The table RAM is walked one entry at a
// time, and a new request is not taken before the last one is done: a
// request is taken again in the cycle after rsp_valid.
// Reset or a csr_we write sets the table to one free block [0, mem_size), or
// empty if mem_size is 0; busy stays high for the one cycle that entry 0 is
// written. Entries past the count are never used, so the RAM needs no
// clearing pass. The user must make csr writes only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module worst_fit_allocator_top
   import wfa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_func,
   input  logic [ADDR_WIDTH-1:0] req_address,
   input  logic [15:0]           req_size,
   output logic                  rsp_valid,
   output logic [15:0]           rsp_address_out,
   output logic [1:0]            rsp_status,
   input  logic                  csr_we,
   input  logic [15:0]           csr_wdata
);

   state_type state_ff, state_in;

   logic [ADDR_WIDTH-1:0] base_mem [MAX_BLOCKS];
   logic [LEN_W-1:0]      len_mem  [MAX_BLOCKS];

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      largest_ff, largest_in;
   logic [ADDR_WIDTH-1:0] lbase_ff, lbase_in;   // largest block, cached
   logic [LEN_W-1:0]      llen_ff, llen_in;
   logic [15:0]           msize_ff;
   logic                  func_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic [15:0]           size_ff;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [ADDR_WIDTH-1:0] pbase_ff, pbase_in;   // entry at pos (next)
   logic [LEN_W-1:0]      plen_ff, plen_in;
   logic [ADDR_WIDTH-1:0] qbase_ff, qbase_in;   // entry at pos-1 (prev)
   logic [LEN_W-1:0]      qlen_ff, qlen_in;
   logic [1:0]            st_ff, st_in;
   logic [15:0]           aout_ff, aout_in;

   // one read port, one write port
   logic [IDX_W-1:0]      rd_idx;
   logic [ADDR_WIDTH-1:0] rd_base;
   logic [LEN_W-1:0]      rd_len;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_idx;
   logic [ADDR_WIDTH-1:0] wr_base;
   logic [LEN_W-1:0]      wr_len;
   logic                  rd_ok_ff, rd_ok_in;   // read data valid; in the scans it belongs to ptr-1

   logic [LEN_W-1:0]      limit;
   logic [LEN_W-1:0]      end_w;
   logic [LEN_W-1:0]      qend;
   logic                  init;

   assign limit = LEN_W'(msize_ff) > ((LEN_W'(1) << ADDR_WIDTH) - 1'b1)
                ? ((LEN_W'(1) << ADDR_WIDTH) - 1'b1) : LEN_W'(msize_ff);
   assign end_w = LEN_W'(addr_ff) + LEN_W'(size_ff);
   assign qend  = LEN_W'(qbase_ff) + qlen_ff;
   assign init  = reset | csr_we;

   // table RAM
   always_ff @(posedge clock) begin
      if (wr_en) begin
         base_mem[wr_idx] <= wr_base;
         len_mem[wr_idx]  <= wr_len;
      end
      rd_base <= base_mem[rd_idx];
      rd_len  <= len_mem[rd_idx];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         msize_ff <= 16'hFFFF;
      end else begin
         state_ff <= state_in;
         if (csr_we) msize_ff <= csr_wdata;
      end
      if (init) begin
         count_ff   <= '0;
         largest_ff <= '0;
      end else begin
         count_ff   <= count_in;
         largest_ff <= largest_in;
      end
      if (start && !busy) begin
         func_ff <= req_func;
         addr_ff <= req_address;
         size_ff <= req_size;
      end
      lbase_ff <= lbase_in;
      llen_ff  <= llen_in;
      ptr_ff   <= ptr_in;
      pos_ff   <= pos_in;
      pbase_ff <= pbase_in;
      plen_ff  <= plen_in;
      qbase_ff <= qbase_in;
      qlen_ff  <= qlen_in;
      st_ff    <= st_in;
      aout_ff  <= aout_in;
      rd_ok_ff <= rd_ok_in;
   end

   // pending init: entry 0 written the cycle after reset/csr write
   logic init_pend_ff;
   always_ff @(posedge clock) begin
      init_pend_ff <= init;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (start && !init_pend_ff) state_in = req_func ? S_FSCAN : S_ALLOC;
         S_ALLOC: begin
            if (count_ff == '0 || LEN_W'(size_ff) > llen_ff || size_ff == '0)
               state_in = S_DONE;
            else if (LEN_W'(size_ff) == llen_ff) state_in = S_SHDN;
            else state_in = S_LARGE;
         end
         S_FSCAN: begin
            if (size_ff == '0 || end_w > limit) state_in = S_DONE;
            else if (rd_ok_ff && (ptr_ff - 1'b1) < count_ff
                     && rd_base > addr_ff) state_in = S_FPREV;
            else if (ptr_ff >= count_ff && (!rd_ok_ff || ptr_ff - 1'b1 >= count_ff))
               state_in = S_FPREV;
         end
         S_FPREV:   if (rd_ok_ff) state_in = S_FDECIDE;
         S_FDECIDE: begin
            if ((pos_ff != '0 && qend > LEN_W'(addr_ff)) ||
                (pos_ff < count_ff && end_w > LEN_W'(pbase_ff)))
               state_in = S_DONE;
            else if (pos_ff != '0 && qend == LEN_W'(addr_ff) &&
                     pos_ff < count_ff && end_w == LEN_W'(pbase_ff))
               state_in = S_SHDN;
            else if ((pos_ff != '0 && qend == LEN_W'(addr_ff)) ||
                     (pos_ff < count_ff && end_w == LEN_W'(pbase_ff)))
               state_in = S_LARGE;
            else if (count_ff >= CNT_W'(MAX_BLOCKS)) state_in = S_DONE;
            else state_in = S_SHUP;
         end
         S_SHDN:    if (ptr_ff + 1'b1 >= count_ff && !rd_ok_ff) state_in = S_LARGE;
         S_SHUP:    if (ptr_ff <= pos_ff && !rd_ok_ff) state_in = S_LARGE;
         S_LARGE:   if (ptr_ff > count_ff) state_in = S_DONE;
         S_DONE:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
      if (init) state_in = S_IDLE;
   end

   // datapath and outputs
   always_comb begin
      count_in   = count_ff;
      largest_in = largest_ff;
      lbase_in   = lbase_ff;
      llen_in    = llen_ff;
      ptr_in     = ptr_ff;
      pos_in     = pos_ff;
      pbase_in   = pbase_ff;
      plen_in    = plen_ff;
      qbase_in   = qbase_ff;
      qlen_in    = qlen_ff;
      st_in      = st_ff;
      aout_in    = aout_ff;
      rd_idx     = IDX_W'(ptr_ff);
      rd_ok_in   = 1'b0;
      wr_en      = 1'b0;
      wr_idx     = '0;
      wr_base    = '0;
      wr_len     = '0;
      if (init_pend_ff) begin
         wr_en    = 1'b1;
         wr_len   = limit;
         count_in = (limit != '0) ? CNT_W'(1) : '0;
         lbase_in = '0;
         llen_in  = limit;
      end
      unique case (state_ff)
         S_IDLE: begin
            ptr_in   = '0;
            st_in    = ST_OK;
            aout_in  = '0;
         end
         S_ALLOC: begin
            if (count_ff == '0 || LEN_W'(size_ff) > llen_ff) begin
               st_in = ST_NOFIT;
            end else begin
               aout_in = 16'(lbase_ff);
               if (size_ff != '0 && LEN_W'(size_ff) != llen_ff) begin
                  wr_en   = 1'b1;
                  wr_idx  = largest_ff;
                  wr_base = lbase_ff + ADDR_WIDTH'(size_ff);
                  wr_len  = llen_ff - LEN_W'(size_ff);
               end
               ptr_in = CNT_W'(largest_ff);
               pos_in = CNT_W'(largest_ff);
               if (LEN_W'(size_ff) != llen_ff) ptr_in = '0;
            end
         end
         S_FSCAN: begin
            // issue read at ptr; data for ptr-1 arrives this cycle if rd_ok
            if (size_ff == '0) st_in = ST_OK;
            else if (end_w > limit) st_in = ST_OVERLAP;
            if (rd_ok_ff && (ptr_ff - 1'b1) < count_ff && rd_base > addr_ff) begin
               pos_in   = ptr_ff - 1'b1;
               pbase_in = rd_base;
               plen_in  = rd_len;
               rd_idx   = IDX_W'(ptr_ff - 2'd2);
               rd_ok_in = 1'b1;
            end else if (ptr_ff >= count_ff &&
                         (!rd_ok_ff || ptr_ff - 1'b1 >= count_ff)) begin
               pos_in   = count_ff;
               rd_idx   = IDX_W'(count_ff - 1'b1);
               rd_ok_in = 1'b1;
            end else begin
               rd_ok_in = 1'b1;
               ptr_in   = ptr_ff + 1'b1;
            end
         end
         S_FPREV: begin
            qbase_in = rd_base;
            qlen_in  = rd_len;
         end
         S_FDECIDE: begin
            ptr_in = '0;
            if ((pos_ff != '0 && qend > LEN_W'(addr_ff)) ||
                (pos_ff < count_ff && end_w > LEN_W'(pbase_ff))) begin
               st_in = ST_OVERLAP;
            end else if (pos_ff != '0 && qend == LEN_W'(addr_ff)) begin
               wr_en   = 1'b1;
               wr_idx  = IDX_W'(pos_ff - 1'b1);
               wr_base = qbase_ff;
               if (pos_ff < count_ff && end_w == LEN_W'(pbase_ff)) begin
                  wr_len = qlen_ff + LEN_W'(size_ff) + plen_ff;
                  ptr_in = pos_ff;
               end else begin
                  wr_len = qlen_ff + LEN_W'(size_ff);
               end
            end else if (pos_ff < count_ff && end_w == LEN_W'(pbase_ff)) begin
               wr_en   = 1'b1;
               wr_idx  = IDX_W'(pos_ff);
               wr_base = addr_ff;
               wr_len  = plen_ff + LEN_W'(size_ff);
            end else if (count_ff >= CNT_W'(MAX_BLOCKS)) begin
               st_in = ST_FULL;
            end else begin
               ptr_in = count_ff;
            end
         end
         S_SHDN: begin
            // read ptr+1, write it to ptr next cycle
            if (rd_ok_ff) begin
               wr_en   = 1'b1;
               wr_idx  = IDX_W'(ptr_ff);
               wr_base = rd_base;
               wr_len  = rd_len;
               ptr_in  = ptr_ff + 1'b1;
            end else if (ptr_ff + 1'b1 < count_ff) begin
               rd_idx   = IDX_W'(ptr_ff + 1'b1);
               rd_ok_in = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               ptr_in   = '0;
            end
         end
         S_SHUP: begin
            // read ptr-1, write it to ptr; at pos write the new entry
            if (rd_ok_ff) begin
               wr_en   = 1'b1;
               wr_idx  = IDX_W'(ptr_ff);
               wr_base = rd_base;
               wr_len  = rd_len;
               ptr_in  = ptr_ff - 1'b1;
            end else if (ptr_ff > pos_ff) begin
               rd_idx   = IDX_W'(ptr_ff - 1'b1);
               rd_ok_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_idx   = IDX_W'(pos_ff);
               wr_base  = addr_ff;
               wr_len   = LEN_W'(size_ff);
               count_in = count_ff + 1'b1;
               ptr_in   = '0;
            end
         end
         S_LARGE: begin
            // read ptr, compare data of ptr-1
            rd_ok_in = 1'b1;
            ptr_in   = ptr_ff + 1'b1;
            if (ptr_ff == '0) begin
               largest_in = '0;
               llen_in    = '0;
               lbase_in   = '0;
            end else if (rd_ok_ff && (ptr_ff - 1'b1) < count_ff &&
                         (ptr_ff == CNT_W'(1) || rd_len > llen_ff)) begin
               largest_in = IDX_W'(ptr_ff - 1'b1);
               llen_in    = rd_len;
               lbase_in   = rd_base;
            end
            if (ptr_ff > count_ff) largest_in = (count_ff == '0) ? '0 : largest_in;
         end
         S_DONE: ;
         default: ;
      endcase
   end

   // busy also covers the cycle that entry 0 is rewritten
   assign busy            = (state_ff != S_IDLE) || init_pend_ff;
   assign rsp_valid       = (state_ff == S_DONE);
   assign rsp_address_out = aout_ff;
   assign rsp_status      = st_ff;

endmodule
